// ===== hdl/bilu_pkg.sv =====
// ----------------------------------------------------------------------------
// Bilinear upscaler package
// Shared widths, register and mode codes, the sideband type that travels
// through the divider, and the per-channel blend function.
// ----------------------------------------------------------------------------
package bilu_pkg;

  localparam int CoordW = 13;
  localparam int DimW   = 13;
  localparam int IndexW = 17;
  localparam int ColorW = 24;
  localparam int PixelW = 32;
  localparam int FracW  = 8;

  // Configuration register indexes.
  localparam logic [0:0] REG_OUT_WIDTH  = 1'b0;
  localparam logic [0:0] REG_OUT_HEIGHT = 1'b1;

  localparam logic [DimW-1:0] OUT_WIDTH_RESET  = 13'd320;
  localparam logic [DimW-1:0] OUT_HEIGHT_RESET = 13'd240;

  // Item kinds on the input channel.
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Sideband carried alongside each item through the divider.
  typedef struct packed {
    logic              load;     // item writes a source pixel
    logic              wr;       // load index lies inside the image
    logic              nearest;  // nearest-pixel mode for this request
    logic [ColorW-1:0] color;    // color to store on a load
  } item_tag_t;

  // (a*(256-f) + b*f) >> 8 on one 8-bit channel.
  function automatic logic [7:0] blend_ch(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] f);
    logic [8:0]  g;
    logic [17:0] s;
    g = 9'd256 - {1'b0, f};
    s = 18'(a) * 18'(g) + 18'(b) * 18'(f);
    return s[15:8];
  endfunction

  function automatic logic [ColorW-1:0] blend_px(input logic [ColorW-1:0] a,
                                                 input logic [ColorW-1:0] b,
                                                 input logic [7:0] f);
    return {blend_ch(a[23:16], b[23:16], f),
            blend_ch(a[15:8],  b[15:8],  f),
            blend_ch(a[7:0],   b[7:0],   f)};
  endfunction

endpackage

// ===== hdl/bilu_if.sv =====
// ----------------------------------------------------------------------------
// Bilinear upscaler channels
// Valid/ready channels for input items and for output pixels.
// ----------------------------------------------------------------------------
interface bilu_in_if import bilu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [IndexW-1:0] src_index;
  logic [ColorW-1:0] src_color;
  logic [CoordW-1:0] out_x;
  logic [CoordW-1:0] out_y;

  modport source (output valid, mode, src_index, src_color, out_x, out_y, input ready);
  modport sink   (input valid, mode, src_index, src_color, out_x, out_y, output ready);
endinterface

interface bilu_out_if import bilu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PixelW-1:0] pixel;

  modport source (output valid, pixel, input ready);
  modport sink   (input valid, pixel, output ready);
endinterface

// ===== hdl/bilinear_image_upscaler.sv =====
// ----------------------------------------------------------------------------
// Bilinear image upscaler
// Source image store with per-request bilinear or nearest resampling.
// ----------------------------------------------------------------------------
// Usage. Items arrive on in_chan. A load item (mode 0) writes src_color into
// the source image at raster index src_index; indexes past the image are
// dropped and a load never yields a result. A request item (mode 1) names an
// output pixel (out_x, out_y) and yields exactly one transfer on out_chan
// with the pixel as alpha 0xFF over red, green and blue. The output size is
// set through the APB registers out_width and out_height (a value of 0 acts
// as 1); write them only while no item is in flight. Above MAX_BILINEAR_DIM
// in either dimension the nearest source pixel is returned.
// Throughput is one item per clock while out_chan does not stall. A request
// passes the input register, the divider, stages P and A, the bank read
// and the blend registers on its way to out_chan. The restoring divider
// resolves one bit of each source position per stage, both axes side by side.
// The image is held in four RAM banks split by row and column parity, so all
// four taps are read in one cycle; loads write at that same stage, which
// keeps reads and writes in item order. Reset empties the pipeline and
// restores the size registers; image contents are undefined until loaded.
// When out_chan stalls, the whole pipeline and in_chan.ready hold.
// ----------------------------------------------------------------------------
module bilinear_image_upscaler
  import bilu_pkg::*;
#(
  parameter int SRC_WIDTH        = 320,
  parameter int SRC_HEIGHT       = 240,
  parameter int MAX_BILINEAR_DIM = 4096
) (
  input  logic        clk,
  input  logic        rst,
  bilu_in_if.sink     in_chan,
  bilu_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SMax      = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
  localparam int QUO_W     = $clog2(SMax) + 16;
  localparam int NumW      = 15 + CoordW + 1 + $clog2(SMax + 1);
  localparam int XW        = $clog2(SRC_WIDTH);
  localparam int YW        = $clog2(SRC_HEIGHT);
  localparam int HalfW     = (SRC_WIDTH + 1) / 2;
  localparam int HalfH     = (SRC_HEIGHT + 1) / 2;
  localparam int BankDepth = HalfW * HalfH;
  localparam int BankAW    = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int SrcPixels = SRC_WIDTH * SRC_HEIGHT;

  localparam logic [QUO_W-1:0] HalfPos = QUO_W'(32768);
  localparam logic [QUO_W-1:0] MaxPosX = QUO_W'(SRC_WIDTH - 1) << 16;
  localparam logic [QUO_W-1:0] MaxPosY = QUO_W'(SRC_HEIGHT - 1) << 16;
  localparam logic [XW-1:0]    LastX   = XW'(SRC_WIDTH - 1);
  localparam logic [YW-1:0]    LastY   = YW'(SRC_HEIGHT - 1);

  // ---------------------------------------------------------------------
  // Configuration registers. Only address bit 2 selects the register.
  // ---------------------------------------------------------------------
  logic [DimW-1:0] out_width;
  logic [DimW-1:0] out_height;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_width  <= OUT_WIDTH_RESET;
      out_height <= OUT_HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_OUT_WIDTH:  out_width  <= pwdata[DimW-1:0];
        REG_OUT_HEIGHT: out_height <= pwdata[DimW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_OUT_WIDTH:  prdata = 32'(out_width);
      REG_OUT_HEIGHT: prdata = 32'(out_height);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Global advance: every stage moves unless a finished pixel is waiting.
  // ---------------------------------------------------------------------
  logic adv;

  assign adv           = !out_chan.valid || out_chan.ready;
  assign in_chan.ready = adv;

  // ---------------------------------------------------------------------
  // Stage 0: input register.
  // ---------------------------------------------------------------------
  logic              s0_valid;
  logic              s0_mode;
  logic [IndexW-1:0] s0_idx;
  logic [ColorW-1:0] s0_color;
  logic [CoordW-1:0] s0_x;
  logic [CoordW-1:0] s0_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_mode  <= in_chan.mode;
      s0_idx   <= in_chan.src_index;
      s0_color <= in_chan.src_color;
      s0_x     <= in_chan.out_x;
      s0_y     <= in_chan.out_y;
    end
  end

  // Numerators for the divider. Bilinear uses ((2i+1)*S) << 15, nearest
  // uses i*S, and a load splits its raster index by the image width.
  logic [DimW-1:0]   w_eff;
  logic [DimW-1:0]   h_eff;
  logic              s0_nearest;
  logic [NumW-1:0]   div_num [2];
  logic [DimW-1:0]   div_den [2];
  item_tag_t         s0_tag;

  always_comb begin
    w_eff      = (out_width == '0) ? DimW'(1) : out_width;
    h_eff      = (out_height == '0) ? DimW'(1) : out_height;
    s0_nearest = ({1'b0, w_eff} > 14'(MAX_BILINEAR_DIM))
              || ({1'b0, h_eff} > 14'(MAX_BILINEAR_DIM));

    s0_tag.load    = (s0_mode == MODE_LOAD);
    s0_tag.wr      = (s0_mode == MODE_LOAD) && (32'(s0_idx) < 32'(SrcPixels));
    s0_tag.nearest = s0_nearest;
    s0_tag.color   = s0_color;

    if (s0_mode == MODE_LOAD) begin
      div_num[0] = '0;
      div_den[0] = DimW'(1);
      div_num[1] = NumW'(s0_idx);
      div_den[1] = DimW'(SRC_WIDTH);
    end else if (s0_nearest) begin
      div_num[0] = NumW'(s0_x) * NumW'(SRC_WIDTH);
      div_den[0] = w_eff;
      div_num[1] = NumW'(s0_y) * NumW'(SRC_HEIGHT);
      div_den[1] = h_eff;
    end else begin
      div_num[0] = (NumW'({s0_x, 1'b1}) * NumW'(SRC_WIDTH)) << 15;
      div_den[0] = w_eff;
      div_num[1] = (NumW'({s0_y, 1'b1}) * NumW'(SRC_HEIGHT)) << 15;
      div_den[1] = h_eff;
    end
  end

  // ---------------------------------------------------------------------
  // Divider stages: lane 0 is the x axis, lane 1 the y axis.
  // ---------------------------------------------------------------------
  logic             dv_valid;
  item_tag_t        dv_tag;
  logic [QUO_W-1:0] dv_quo [2];
  logic [DimW-1:0]  dv_rem [2];

  bilu_div #(
    .NUM_W (NumW),
    .QUO_W (QUO_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s0_valid),
    .in_tag    (s0_tag),
    .num       (div_num),
    .den       (div_den),
    .out_valid (dv_valid),
    .out_tag   (dv_tag),
    .quo       (dv_quo),
    .rem       (dv_rem)
  );

  // ---------------------------------------------------------------------
  // Stage P: clamp the source position, split into index and fraction.
  // ---------------------------------------------------------------------
  logic [QUO_W-1:0] pos_x;
  logic [QUO_W-1:0] pos_y;
  logic [XW-1:0]    c_x0;
  logic [YW-1:0]    c_y0;
  logic [FracW-1:0] c_fx;
  logic [FracW-1:0] c_fy;

  always_comb begin
    pos_x = (dv_quo[0] < HalfPos) ? '0 : dv_quo[0] - HalfPos;
    if (pos_x > MaxPosX) begin
      pos_x = MaxPosX;
    end
    pos_y = (dv_quo[1] < HalfPos) ? '0 : dv_quo[1] - HalfPos;
    if (pos_y > MaxPosY) begin
      pos_y = MaxPosY;
    end

    if (dv_tag.load) begin
      c_x0 = dv_rem[1][XW-1:0];
      c_y0 = dv_quo[1][YW-1:0];
      c_fx = '0;
      c_fy = '0;
    end else if (dv_tag.nearest) begin
      c_x0 = (dv_quo[0] > QUO_W'(SRC_WIDTH - 1)) ? LastX : dv_quo[0][XW-1:0];
      c_y0 = (dv_quo[1] > QUO_W'(SRC_HEIGHT - 1)) ? LastY : dv_quo[1][YW-1:0];
      c_fx = '0;
      c_fy = '0;
    end else begin
      c_x0 = pos_x[16 +: XW];
      c_y0 = pos_y[16 +: YW];
      c_fx = pos_x[15:8];
      c_fy = pos_y[15:8];
    end
  end

  logic             p_valid;
  item_tag_t        p_tag;
  logic [XW-1:0]    p_x0;
  logic [XW-1:0]    p_x1;
  logic [YW-1:0]    p_y0;
  logic [YW-1:0]    p_y1;
  logic [FracW-1:0] p_fx;
  logic [FracW-1:0] p_fy;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (adv) begin
      p_valid <= dv_valid;
    end
  end

  // At the last row or column the second tap repeats the first. In nearest
  // mode all four taps are the one selected pixel, so no neighbor is read.
  always_ff @(posedge clk) begin
    if (adv) begin
      p_tag <= dv_tag;
      p_x0  <= c_x0;
      p_x1  <= (!dv_tag.nearest && c_x0 < LastX) ? XW'(c_x0 + 1'b1) : c_x0;
      p_y0  <= c_y0;
      p_y1  <= (!dv_tag.nearest && c_y0 < LastY) ? YW'(c_y0 + 1'b1) : c_y0;
      p_fx  <= c_fx;
      p_fy  <= c_fy;
    end
  end

  // ---------------------------------------------------------------------
  // Stage A: bank addresses. Bank {row parity, column parity} holds every
  // pixel of that parity, so distinct taps always hit distinct banks.
  // ---------------------------------------------------------------------
  logic [XW-1:0]     bank_cx   [4];
  logic [YW-1:0]     bank_cy   [4];
  logic [BankAW-1:0] bank_addr [4];
  logic [3:0]        bank_hit;

  always_comb begin
    for (int b = 0; b < 4; b++) begin
      bank_cx[b]   = (p_x0[0] == b[0]) ? p_x0 : p_x1;
      bank_cy[b]   = (p_y0[0] == b[1]) ? p_y0 : p_y1;
      bank_addr[b] = BankAW'((32'(bank_cy[b]) >> 1) * HalfW + (32'(bank_cx[b]) >> 1));
      bank_hit[b]  = ({p_y0[0], p_x0[0]} == 2'(b));
    end
  end

  logic              a_valid;
  logic              a_load;
  logic              a_wr;
  logic [ColorW-1:0] a_color;
  logic [BankAW-1:0] a_addr [4];
  logic [3:0]        a_hit;
  logic [FracW-1:0]  a_fx;
  logic [FracW-1:0]  a_fy;
  logic              a_x0p;
  logic              a_y0p;
  logic              a_xeq;
  logic              a_yeq;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_load  <= p_tag.load;
      a_wr    <= p_tag.wr;
      a_color <= p_tag.color;
      a_addr  <= bank_addr;
      a_hit   <= bank_hit;
      a_fx    <= p_fx;
      a_fy    <= p_fy;
      a_x0p   <= p_x0[0];
      a_y0p   <= p_y0[0];
      a_xeq   <= (p_x1 == p_x0);
      a_yeq   <= (p_y1 == p_y0);
    end
  end

  // ---------------------------------------------------------------------
  // Source image banks. Loads write here, at the same stage where requests
  // read, so every request sees exactly the loads that came before it.
  // ---------------------------------------------------------------------
  logic [3:0]        ram_we;
  logic [ColorW-1:0] bank_q [4];

  assign ram_we = (adv && a_valid && a_load && a_wr) ? a_hit : 4'b0000;

  for (genvar b = 0; b < 4; b++) begin : g_bank
    bilu_ram #(
      .WIDTH (ColorW),
      .DEPTH (BankDepth)
    ) u_ram (
      .clk   (clk),
      .we    (ram_we[b]),
      .waddr (a_addr[b]),
      .wdata (a_color),
      .re    (adv),
      .raddr (a_addr[b]),
      .rdata (bank_q[b])
    );
  end

  logic             m_valid;
  logic             m_load;
  logic [FracW-1:0] m_fx;
  logic [FracW-1:0] m_fy;
  logic             m_x0p;
  logic             m_y0p;
  logic             m_xeq;
  logic             m_yeq;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (adv) begin
      m_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_load <= a_load;
      m_fx   <= a_fx;
      m_fy   <= a_fy;
      m_x0p  <= a_x0p;
      m_y0p  <= a_y0p;
      m_xeq  <= a_xeq;
      m_yeq  <= a_yeq;
    end
  end

  // Route bank outputs back to tap order.
  logic              m_x1p;
  logic              m_y1p;
  logic [ColorW-1:0] taps [4];

  always_comb begin
    m_x1p   = m_xeq ? m_x0p : !m_x0p;
    m_y1p   = m_yeq ? m_y0p : !m_y0p;
    taps[0] = bank_q[{m_y0p, m_x0p}];
    taps[1] = bank_q[{m_y1p, m_x0p}];
    taps[2] = bank_q[{m_y0p, m_x1p}];
    taps[3] = bank_q[{m_y1p, m_x1p}];
  end

  // ---------------------------------------------------------------------
  // Blend stages and output register. Loads leave the pipeline here.
  // ---------------------------------------------------------------------
  bilu_blend u_blend (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (m_valid && !m_load),
    .taps      (taps),
    .frac_x    (m_fx),
    .frac_y    (m_fy),
    .res_valid (out_chan.valid),
    .res_pixel (out_chan.pixel)
  );

`ifndef SYNTHESIS
  // A load writes one bank at most.
  assert property (@(posedge clk) disable iff (rst) $onehot0(ram_we))
    else $error("more than one source bank written in a cycle");

  // Nothing is written while the pipeline is held.
  assert property (@(posedge clk) disable iff (rst) !adv |-> (ram_we == 4'b0000))
    else $error("source bank written during a stall");

  // A waiting pixel must hold off new input transfers.
  assert property (@(posedge clk) disable iff (rst)
                   (out_chan.valid && !out_chan.ready) |-> !in_chan.ready)
    else $error("input accepted while output is stalled");

  // Tap coordinates stay inside the source image.
  assert property (@(posedge clk) disable iff (rst)
                   (p_valid && !(p_tag.load && !p_tag.wr))
                   |-> (p_x0 <= LastX && p_x1 <= LastX && p_y0 <= LastY && p_y1 <= LastY))
    else $error("tap coordinate outside the source image");
`endif

endmodule

// ===== hdl/bilu_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module bilu_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AddrW-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AddrW-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/bilu_div.sv =====
// ----------------------------------------------------------------------------
// Pipelined divider, two lanes
// Restoring division, one quotient bit per stage. A quotient that does not
// fit in QUO_W bits saturates to all ones.
// ----------------------------------------------------------------------------
module bilu_div
  import bilu_pkg::*;
#(
  parameter int NUM_W = 38,
  parameter int QUO_W = 25
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             in_valid,
  input  item_tag_t        in_tag,
  input  logic [NUM_W-1:0] num [2],
  input  logic [DimW-1:0]  den [2],
  output logic             out_valid,
  output item_tag_t        out_tag,
  output logic [QUO_W-1:0] quo [2],
  output logic [DimW-1:0]  rem [2]
);

  localparam int HiW  = NUM_W - QUO_W;
  localparam int CmpW = (HiW > DimW) ? HiW : DimW;

  logic             valid_q [QUO_W+1];
  item_tag_t        tag_q   [QUO_W+1];
  logic [DimW-1:0]  rem_q   [2][QUO_W+1];
  logic [DimW-1:0]  den_q   [2][QUO_W+1];
  logic [QUO_W-1:0] quo_q   [2][QUO_W+1];
  logic [QUO_W-1:0] low_q   [2][QUO_W+1];
  logic             ovf_q   [2][QUO_W+1];

  logic [HiW-1:0]   hi      [2];
  logic             ovf     [2];
  logic [DimW:0]    trial   [2][QUO_W];
  logic             take    [2][QUO_W];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      hi[l]  = num[l][NUM_W-1:QUO_W];
      ovf[l] = CmpW'(hi[l]) >= CmpW'(den[l]);
      for (int k = 0; k < QUO_W; k++) begin
        trial[l][k] = {rem_q[l][k], low_q[l][k][QUO_W-1]};
        take[l][k]  = trial[l][k] >= {1'b0, den_q[l][k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= QUO_W; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (adv) begin
      valid_q[0] <= in_valid;
      for (int k = 0; k < QUO_W; k++) begin
        valid_q[k+1] <= valid_q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tag_q[0] <= in_tag;
      for (int k = 0; k < QUO_W; k++) begin
        tag_q[k+1] <= tag_q[k];
      end
      for (int l = 0; l < 2; l++) begin
        rem_q[l][0] <= ovf[l] ? '0 : DimW'(hi[l]);
        den_q[l][0] <= den[l];
        quo_q[l][0] <= '0;
        low_q[l][0] <= num[l][QUO_W-1:0];
        ovf_q[l][0] <= ovf[l];
        for (int k = 0; k < QUO_W; k++) begin
          rem_q[l][k+1] <= take[l][k] ? DimW'(trial[l][k] - {1'b0, den_q[l][k]})
                                      : trial[l][k][DimW-1:0];
          den_q[l][k+1] <= den_q[l][k];
          quo_q[l][k+1] <= {quo_q[l][k][QUO_W-2:0], take[l][k]};
          low_q[l][k+1] <= low_q[l][k] << 1;
          ovf_q[l][k+1] <= ovf_q[l][k];
        end
      end
    end
  end

  assign out_valid = valid_q[QUO_W];
  assign out_tag   = tag_q[QUO_W];

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quo[l] = ovf_q[l][QUO_W] ? '1 : quo_q[l][QUO_W];
      rem[l] = rem_q[l][QUO_W];
    end
  end

endmodule

// ===== hdl/bilu_blend.sv =====
// ----------------------------------------------------------------------------
// Bilinear blend stages
// Vertical blend of both tap columns, then horizontal blend into the output
// register with alpha attached.
// ----------------------------------------------------------------------------
module bilu_blend import bilu_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [ColorW-1:0] taps [4],
  input  logic [FracW-1:0]  frac_x,
  input  logic [FracW-1:0]  frac_y,
  output logic              res_valid,
  output logic [PixelW-1:0] res_pixel
);

  // taps: 0 = (x0,y0), 1 = (x0,y1), 2 = (x1,y0), 3 = (x1,y1)
  logic              v_valid;
  logic [ColorW-1:0] v_left;
  logic [ColorW-1:0] v_right;
  logic [FracW-1:0]  v_fx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (adv) begin
      v_valid   <= in_valid;
      res_valid <= v_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      v_left    <= blend_px(taps[0], taps[1], frac_y);
      v_right   <= blend_px(taps[2], taps[3], frac_y);
      v_fx      <= frac_x;
      res_pixel <= {ALPHA_OPAQUE, blend_px(v_left, v_right, v_fx)};
    end
  end

endmodule

// ===== tb/tb_bilinear_image_upscaler.sv =====
// ----------------------------------------------------------------------------
// Bilinear image upscaler testbench
// Loads source pixels and requests output pixels over the valid/ready
// channels, moves the output size through several settings over APB, and
// checks every pixel against a local resampling predictor or a typed answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bilinear_image_upscaler;
  import bilu_pkg::*;

  localparam int SrcW       = 320;
  localparam int SrcH       = 240;
  localparam int SrcPixels  = SrcW * SrcH;
  localparam int BilinMax   = 4096;
  localparam int BlockSide  = 16;    // side of the top-left block loaded up front
  localparam int DrawTries  = 64;    // draws per request before the corner fallback
  localparam int DrainWait  = 64;    // comfortably past the pipeline latency
  localparam int StallLimit = 4000;  // cycles without any transfer

  // APB byte addresses of the two size registers.
  localparam logic [2:0] ADDR_OUT_WIDTH  = {REG_OUT_WIDTH, 2'b00};
  localparam logic [2:0] ADDR_OUT_HEIGHT = {REG_OUT_HEIGHT, 2'b00};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bilu_in_if  in_if ();
  bilu_out_if out_if ();

  bilinear_image_upscaler dut (
    .clk      (clk),
    .rst      (rst),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: a private copy of the image and of the size registers.
  logic [ColorW-1:0] image_copy [SrcPixels];
  bit                loaded     [SrcPixels];
  logic [DimW-1:0]   width_copy;
  logic [DimW-1:0]   height_copy;

  // Output pixels still owed by the block, oldest first.
  logic [PixelW-1:0] pending_pixels [$];

  int  errors = 0;
  bit  calm = 1'b0;       // when set, neither side idles
  int  quiet_cycles = 0;  // cycles since the last transfer of any kind

  // One directed row. has_pixel marks rows whose answer is typed in.
  typedef struct {
    logic              mode;
    logic [IndexW-1:0] index;
    logic [ColorW-1:0] color;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    bit                has_pixel;
    logic [PixelW-1:0] pixel;
  } directed_row_t;

  // Per-channel blend (a*(256-f) + b*f) >> 8 on all three channels.
  function automatic logic [ColorW-1:0] mix(input logic [ColorW-1:0] a,
                                            input logic [ColorW-1:0] b,
                                            input int f);
    logic [ColorW-1:0] r;
    for (int c = 0; c < 3; c++) begin
      r[c*8 +: 8] = 8'(((int'(a[c*8 +: 8]) * (256 - f)) + (int'(b[c*8 +: 8]) * f)) >> 8);
    end
    return r;
  endfunction

  // Source position along one axis: integer tap and 8-bit fraction.
  function automatic void source_pos(input int i, input int s, input int d,
                                     output int tap, output int frac);
    longint p;
    longint top;
    p = ((longint'(2 * i + 1) * s) << 15) / d - 32768;
    top = longint'(s - 1) << 16;
    if (p < 0) p = 0;
    if (p > top) p = top;
    tap = int'(p >> 16);
    frac = int'((p >> 8) & 255);
  endfunction

  function automatic logic [PixelW-1:0] upscale_pixel(input int x, input int y);
    int w, h, x0, x1, y0, y1, fx, fy;
    logic [ColorW-1:0] left, right, rgb;
    w = (width_copy == 0) ? 1 : int'(width_copy);
    h = (height_copy == 0) ? 1 : int'(height_copy);
    if (w > BilinMax || h > BilinMax) begin
      // Nearest pixel, saturating for coordinates past the output size.
      y0 = (y * SrcH) / h;
      x0 = (x * SrcW) / w;
      if (y0 > SrcH - 1) y0 = SrcH - 1;
      if (x0 > SrcW - 1) x0 = SrcW - 1;
      rgb = image_copy[y0 * SrcW + x0];
    end else begin
      source_pos(x, SrcW, w, x0, fx);
      source_pos(y, SrcH, h, y0, fy);
      // At the last row or column the second tap repeats the first.
      x1 = (x0 < SrcW - 1) ? x0 + 1 : x0;
      y1 = (y0 < SrcH - 1) ? y0 + 1 : y0;
      left  = mix(image_copy[y0 * SrcW + x0], image_copy[y1 * SrcW + x0], fy);
      right = mix(image_copy[y0 * SrcW + x1], image_copy[y1 * SrcW + x1], fy);
      rgb = mix(left, right, fx);
    end
    return {ALPHA_OPAQUE, rgb};
  endfunction

  // True when every source pixel that the request reads has been loaded.
  function automatic bit taps_loaded(input int x, input int y);
    int w, h, x0, x1, y0, y1, fx, fy;
    w = (width_copy == 0) ? 1 : int'(width_copy);
    h = (height_copy == 0) ? 1 : int'(height_copy);
    if (w > BilinMax || h > BilinMax) begin
      y0 = (y * SrcH) / h;
      x0 = (x * SrcW) / w;
      if (y0 > SrcH - 1) y0 = SrcH - 1;
      if (x0 > SrcW - 1) x0 = SrcW - 1;
      return loaded[y0 * SrcW + x0];
    end
    source_pos(x, SrcW, w, x0, fx);
    source_pos(y, SrcH, h, y0, fy);
    x1 = (x0 < SrcW - 1) ? x0 + 1 : x0;
    y1 = (y0 < SrcH - 1) ? y0 + 1 : y0;
    return loaded[y0 * SrcW + x0] && loaded[y1 * SrcW + x0] &&
           loaded[y0 * SrcW + x1] && loaded[y1 * SrcW + x1];
  endfunction

  // Drives one item and waits for its transfer. Random idle cycles are
  // inserted first; valid stays high between back-to-back items. When
  // use_pixel is set the typed-in answer replaces the predicted one.
  task automatic send_item(input logic mode, input logic [IndexW-1:0] index,
                           input logic [ColorW-1:0] color,
                           input logic [CoordW-1:0] x, input logic [CoordW-1:0] y,
                           input bit use_pixel, input logic [PixelW-1:0] pixel);
    if (!calm && $urandom_range(99) < 37) begin
      in_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= mode;
    in_if.src_index <= index;
    in_if.src_color <= color;
    in_if.out_x     <= x;
    in_if.out_y     <= y;
    do @(posedge clk); while (!in_if.ready);
    // The item was transferred at this edge: update the predictor.
    if (mode == MODE_LOAD) begin
      if (index < SrcPixels) begin
        image_copy[index] = color;
        loaded[index] = 1'b1;
      end
    end else begin
      pending_pixels.push_back(use_pixel ? pixel : upscale_pixel(x, y));
    end
  endtask

  // Waits until every expected pixel has arrived and any trailing load has
  // left the pipeline, so that the size registers may change.
  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_size(input int w, input int h);
    drain();
    apb_write(ADDR_OUT_WIDTH, 32'(w));
    apb_write(ADDR_OUT_HEIGHT, 32'(h));
    width_copy  = DimW'(w);
    height_copy = DimW'(h);
  endtask

  // Mostly requests inside the output frame, some past it, and loads with
  // an occasional index beyond the image. Requests are drawn again until
  // they read only loaded pixels; in-frame draws favor the part of the frame
  // that maps onto the loaded top-left block, and the far corner of the
  // frame, which maps onto the loaded bottom-right pixel, is the fallback.
  task automatic random_items(input int count);
    int w, h, xspan, yspan, x, y, tries;
    bit in_frame;
    w = (width_copy == 0) ? 1 : int'(width_copy);
    h = (height_copy == 0) ? 1 : int'(height_copy);
    xspan = (w * (BlockSide + 8)) / SrcW + 1;
    yspan = (h * (BlockSide + 8)) / SrcH + 1;
    if (xspan > w - 1) xspan = w - 1;
    if (yspan > h - 1) yspan = h - 1;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 80) begin
        in_frame = ($urandom_range(99) < 85);
        tries = 0;
        do begin
          if (in_frame) begin
            x = $urandom_range(xspan);
            y = $urandom_range(yspan);
          end else begin
            x = $urandom_range(8190);
            y = $urandom_range(8190);
          end
          tries++;
        end while (!taps_loaded(x, y) && tries < DrawTries);
        if (!taps_loaded(x, y)) begin
          x = 8190;
          y = 8190;
        end
        send_item(MODE_REQUEST, IndexW'($urandom), ColorW'($urandom),
                  CoordW'(x), CoordW'(y), 1'b0, '0);
      end else begin
        if ($urandom_range(99) < 90)
          send_item(MODE_LOAD, IndexW'($urandom_range(SrcPixels - 1)), ColorW'($urandom),
                    CoordW'($urandom), CoordW'($urandom), 1'b0, '0);
        else
          send_item(MODE_LOAD, IndexW'($urandom_range(131071, SrcPixels)),
                    ColorW'($urandom), CoordW'($urandom), CoordW'($urandom), 1'b0, '0);
      end
    end
  endtask

  // Directed rows. Requests here only touch the loaded top-left block and
  // the bottom-right corner.
  directed_row_t directed [] = '{
    '{MODE_LOAD,    17'd0,      24'hFFFFFF, 13'd0,    13'd0,    1'b0, 32'h0},
    '{MODE_LOAD,    17'd1,      24'h000000, 13'd8190, 13'd0,    1'b0, 32'h0},
    '{MODE_LOAD,    17'd320,    24'h000000, 13'd0,    13'd8190, 1'b0, 32'h0},
    '{MODE_LOAD,    17'd321,    24'h000000, 13'd0,    13'd0,    1'b0, 32'h0},
    // At the first output pixel the fraction is zero, so only the first tap counts.
    '{MODE_REQUEST, 17'd131071, 24'hFFFFFF, 13'd0,    13'd0,    1'b1, 32'hFFFFFFFF},
    '{MODE_LOAD,    17'd76799,  24'h123456, 13'd0,    13'd0,    1'b0, 32'h0},
    // Loads past the end of the image are dropped.
    '{MODE_LOAD,    17'd76800,  24'hABCDEF, 13'd0,    13'd0,    1'b0, 32'h0},
    '{MODE_LOAD,    17'd131071, 24'hFFFFFF, 13'd0,    13'd0,    1'b0, 32'h0},
    // Last row and column: both taps are the corner pixel.
    '{MODE_REQUEST, 17'd0,      24'h000000, 13'd319,  13'd239,  1'b1, 32'hFF123456},
    // Far past the output frame the position clamps to the same corner.
    '{MODE_REQUEST, 17'd76799,  24'h000000, 13'd8190, 13'd8190, 1'b1, 32'hFF123456},
    '{MODE_LOAD,    17'd76799,  24'h000000, 13'd0,    13'd0,    1'b0, 32'h0},
    '{MODE_REQUEST, 17'd0,      24'h000000, 13'd8190, 13'd8190, 1'b1, 32'hFF000000},
    // An interior pixel whose taps lie in the loaded block.
    '{MODE_REQUEST, 17'd0,      24'h000000, 13'd1,    13'd1,    1'b0, 32'h0}
  };

  // Output side: random stalls, none while calm is set.
  always @(posedge clk) begin
    out_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
  end

  // Compare each transferred pixel with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual %h", $time, out_if.pixel);
      end else if (out_if.pixel !== pending_pixels[0]) begin
        errors++;
        $display("%0t: pixel mismatch, expected %h, actual %h",
                 $time, pending_pixels[0], out_if.pixel);
        void'(pending_pixels.pop_front());
      end else begin
        void'(pending_pixels.pop_front());
      end
    end
  end

  // Watchdog: ends the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int sizes [9][2];
    in_if.valid     = 1'b0;
    in_if.mode      = MODE_LOAD;
    in_if.src_index = '0;
    in_if.src_color = '0;
    in_if.out_x     = '0;
    in_if.out_y     = '0;
    width_copy      = OUT_WIDTH_RESET;
    height_copy     = OUT_HEIGHT_RESET;
    for (int i = 0; i < SrcPixels; i++) begin
      image_copy[i] = '0;
      loaded[i] = 1'b0;
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Load the top-left block so that requests have pixels to read.
    // The second half runs without any idling.
    for (int i = 0; i < BlockSide * BlockSide; i++) begin
      if (i == (BlockSide * BlockSide) / 2) calm = 1'b1;
      send_item(MODE_LOAD, IndexW'((i / BlockSide) * SrcW + (i % BlockSide)),
                ColorW'($urandom), CoordW'($urandom), CoordW'($urandom), 1'b0, '0);
    end
    calm = 1'b0;

    // Directed part at the reset size.
    foreach (directed[r])
      send_item(directed[r].mode, directed[r].index, directed[r].color,
                directed[r].x, directed[r].y, directed[r].has_pixel, directed[r].pixel);

    // Size settings: the reset size, upscaling, the smallest frames (a zero acts
    // as one), the largest bilinear frame, nearest-pixel frames, a random frame.
    sizes = '{'{320, 240}, '{640, 480}, '{1, 1}, '{0, 0}, '{4096, 4096},
              '{8191, 8191}, '{4097, 100}, '{100, 8191},
              '{0, 0}};
    sizes[8][0] = $urandom_range(4096, 1);
    sizes[8][1] = $urandom_range(4096, 1);
    for (int p = 0; p < 9; p++) begin
      set_size(sizes[p][0], sizes[p][1]);
      calm = (p == 1);
      random_items(185);
    end
    calm = 1'b0;

    drain();
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== bilinear_image_upscaler.f =====
hdl/bilu_pkg.sv
hdl/bilu_if.sv
hdl/bilu_ram.sv
hdl/bilu_div.sv
hdl/bilu_blend.sv
hdl/bilinear_image_upscaler.sv
tb/tb_bilinear_image_upscaler.sv
